// File: src/apbp_pkg.sv
// package for the absolute pointer backdoor port: item types, codes and divider sizes
`default_nettype none
package apbp_pkg;

  // backdoor key and command codes
  localparam logic [31:0] MAGIC_WORD     = 32'h564D_5868;
  localparam logic [31:0] SUB_ENABLE     = 32'h4541_4552;
  localparam logic [31:0] SUB_RELATIVE   = 32'h0000_00F5;
  localparam logic [31:0] SUB_ABSOLUTE   = 32'h5342_4152;
  localparam logic [15:0] CMD_VERSION    = 16'd10;
  localparam logic [15:0] CMD_DATA       = 16'd39;
  localparam logic [15:0] CMD_STATUS     = 16'd40;
  localparam logic [15:0] CMD_POINTER    = 16'd41;
  localparam logic [31:0] STATUS_UPDATED = 32'd4;
  localparam logic [15:0] POS_CENTER     = 16'h7FFF;

  // register write masks
  localparam logic [3:0] MASK_NONE    = 4'h0;
  localparam logic [3:0] MASK_STATUS  = 4'h1;
  localparam logic [3:0] MASK_VERSION = 4'h3;
  localparam logic [3:0] MASK_DATA    = 4'hF;

  // configuration register indexes
  localparam logic [7:0] REG_WIDTH    = 8'd0;
  localparam logic [7:0] REG_HEIGHT   = 8'd1;
  localparam logic [7:0] REG_OFFSET_X = 8'd2;
  localparam logic [7:0] REG_OFFSET_Y = 8'd3;

  // divider sizes: 34-bit dividend, 17-bit divisor, 18-bit quotient
  localparam int NUM_W = 34;
  localparam int DEN_W = 17;
  localparam int QUO_W = 18;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

  typedef enum logic [1:0] {
    OP_PORT_READ = 2'd0,
    OP_MOVE      = 2'd1,
    OP_BUTTONS   = 2'd2,
    OP_WHEEL     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        key_word;
    logic [15:0]        command_code;
    logic [31:0]        sub_command;
    logic [15:0]        host_x;
    logic [15:0]        host_y;
    logic               left_down;
    logic               right_down;
    logic               middle_down;
    logic signed [15:0] wheel_step;
  } apbp_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] second_word;
    logic [15:0] third_word;
    logic [7:0]  fourth_word;
    logic [3:0]  written_mask;
    logic        event_taken;
    logic        unknown_request;
  } apbp_out_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/apbp_div.sv
// restoring divider, one quotient bit per cycle, shared by both axes
`default_nettype none
module apbp_div
  import apbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] sh_r, sh_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one trial subtraction per cycle
  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    if (req.start) begin
      // the quotient fits in QUO_W bits, so the top dividend bits start as remainder
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = DEN_W'(req.num[NUM_W-1:QUO_W]);
      sh_nxt   = req.num[QUO_W-1:0];
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign rsp = '{done: done_r, quo: sh_r};

endmodule
`default_nettype wire

// File: src/absolute_pointer_backdoor_port.sv
// absolute pointer backdoor port: sequencer, device state and output register
// port reads, button and wheel items present their result once it is loaded from the execution state,
// a move after two 18-step divisions on the one shared divider, x then y, then from the done state
// one item at a time: the input stalls from acceptance until the result is loaded,
// and loading waits while the output stalls
// reset (synchronous, rst_n low): relative mode, centred position, buttons, wheel, flag cleared
`default_nettype none
module absolute_pointer_backdoor_port
  import apbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire apbp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output apbp_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIVX = 5'b00100,
    ST_DIVY = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  apbp_in_t  item_r;
  apbp_out_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic [15:0] width_r, height_r, offx_r, offy_r;
  logic        active_r, active_nxt;
  logic        pending_r, pending_nxt;
  logic [2:0]  buttons_r, buttons_nxt;
  logic [15:0] posx_r, posx_nxt, posy_r, posy_nxt;
  logic signed [7:0] wheel_r, wheel_nxt;
  logic [15:0] newx_r, newx_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        out_free;
  logic        use_x;
  logic [15:0] host, clip, res_in, res, pos, d;
  logic [16:0] sat_q;
  logic [15:0] scaled;
  logic signed [16:0] wsum;
  logic        div_start;

  // old y for the change check of a move
  logic [15:0] oldy_r;
  logic        moved;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd640;
      height_r <= 16'd480;
      offx_r   <= '0;
      offy_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WIDTH)    width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT)   height_r <= cfg_data;
      if (cfg_index == REG_OFFSET_X) offx_r   <= cfg_data;
      if (cfg_index == REG_OFFSET_Y) offy_r   <= cfg_data;
    end
  end

  // operand preparation for one axis: clip, clamp, then 2*p*65535 + (r-1) over 2*(r-1)
  assign use_x  = (state_r == ST_EXEC);
  assign host   = use_x ? item_r.host_x : item_r.host_y;
  assign clip   = use_x ? offx_r : offy_r;
  assign res_in = use_x ? width_r : height_r;
  assign res    = (res_in < 16'd2) ? 16'd2 : res_in;
  always_comb begin
    pos = (host > clip) ? 16'(host - clip) : 16'd0;
    if (pos > res) pos = res;
  end
  assign d         = res - 16'd1;
  assign div_start = ((state_r == ST_EXEC) && (item_r.operation == OP_MOVE) && active_r)
                  || ((state_r == ST_DIVX) && div_rsp.done);
  assign div_req   = '{start: div_start,
                       num: {1'b0, pos, 17'd0} - {17'd0, pos, 1'b0} + {18'd0, d},
                       den: {d, 1'b0}};

  apbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // saturate the quotient at full scale
  assign sat_q  = div_rsp.quo[16:0];
  assign scaled = (div_rsp.quo[17] || sat_q[16]) ? 16'hFFFF : sat_q[15:0];

  assign wsum = 17'(wheel_r) + item_r.wheel_step;

  assign moved = (newx_r != posx_r) || (posy_r != oldy_r);

  // sequencer and device state update
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    active_nxt    = active_r;
    pending_nxt   = pending_r;
    buttons_nxt   = buttons_r;
    posx_nxt      = posx_r;
    posy_nxt      = posy_r;
    wheel_nxt     = wheel_r;
    newx_nxt      = newx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if ((item_r.operation == OP_MOVE) && active_r) begin
          state_nxt = ST_DIVX;
        end else if (out_free) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (item_r.operation == OP_PORT_READ) begin
            if (item_r.key_word == MAGIC_WORD) begin
              priority if (item_r.command_code == CMD_VERSION) begin
                out_nxt.second_word  = MAGIC_WORD;
                out_nxt.written_mask = MASK_VERSION;
              end else if (item_r.command_code == CMD_DATA) begin
                out_nxt.read_data    = {26'd0, buttons_r, 3'd0};
                out_nxt.second_word  = {16'd0, posx_r};
                out_nxt.third_word   = posy_r;
                out_nxt.fourth_word  = wheel_r;
                out_nxt.written_mask = MASK_DATA;
                wheel_nxt            = '0;
              end else if (item_r.command_code == CMD_STATUS) begin
                out_nxt.read_data    = pending_r ? STATUS_UPDATED : 32'd0;
                out_nxt.written_mask = MASK_STATUS;
                pending_nxt          = 1'b0;
              end else if (item_r.command_code == CMD_POINTER) begin
                out_nxt.read_data = MAGIC_WORD;
                priority if (item_r.sub_command == SUB_ENABLE) begin
                  out_nxt.unknown_request = 1'b0;
                end else if (item_r.sub_command == SUB_RELATIVE) begin
                  active_nxt  = 1'b0;
                  buttons_nxt = '0;
                  wheel_nxt   = '0;
                end else if (item_r.sub_command == SUB_ABSOLUTE) begin
                  active_nxt  = 1'b1;
                  buttons_nxt = '0;
                  wheel_nxt   = '0;
                end else begin
                  out_nxt.unknown_request = 1'b1;
                end
              end else begin
                out_nxt.read_data       = MAGIC_WORD;
                out_nxt.unknown_request = 1'b1;
              end
            end
          end else if (active_r) begin
            pending_nxt         = 1'b1;
            out_nxt.event_taken = 1'b1;
            if (item_r.operation == OP_BUTTONS) begin
              buttons_nxt = {item_r.left_down, item_r.right_down, item_r.middle_down};
            end else begin
              // wheel accumulates, saturating to a signed byte
              if (wsum > 17'sd127)       wheel_nxt = 8'sd127;
              else if (wsum < -17'sd128) wheel_nxt = -8'sd128;
              else                       wheel_nxt = wsum[7:0];
            end
          end
        end
      end
      ST_DIVX: begin
        if (div_rsp.done) begin
          newx_nxt  = scaled;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_rsp.done) begin
          posy_nxt  = scaled;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // posy_r already holds the new y; compare against the old one kept aside
        if (out_free) begin
          out_nxt             = '0;
          out_nxt.event_taken = moved;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
          posx_nxt            = newx_r;
          pending_nxt         = pending_r || moved;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      pending_r   <= 1'b0;
      buttons_r   <= '0;
      posx_r      <= POS_CENTER;
      posy_r      <= POS_CENTER;
      wheel_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
      buttons_r   <= buttons_nxt;
      posx_r      <= posx_nxt;
      posy_r      <= posy_nxt;
      wheel_r     <= wheel_nxt;
    end
    if ((state_r == ST_IDLE) && in_valid) item_r <= in_data;
    if ((state_r == ST_DIVY) && div_rsp.done) oldy_r <= posy_r;
    newx_r <= newx_nxt;
    out_r  <= out_nxt;
  end

  // checks on the sequencer
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execution");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVX || state_r == ST_DIVY))
    else $error("divider finished outside a division step");
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC || state_r == ST_DONE))
    else $error("result loaded from an unexpected state");

endmodule
`default_nettype wire

// File: verif/absolute_pointer_backdoor_port_test.sv
// self-checking testbench for the absolute pointer backdoor port: predictor, stimulus, checks
module absolute_pointer_backdoor_port_test;
  timeunit 1ns;
  timeprecision 1ps;

  import apbp_pkg::*;

  // tracks the device state and holds the replies it should give
  class pointer_tracker;
    logic [15:0] width_reg, height_reg, clip_x, clip_y;
    bit          absolute_mode;
    bit          updated_flag;
    logic [2:0]  buttons;
    logic [15:0] pos_x, pos_y;
    int          wheel_sum;
    apbp_out_t   expected_replies[$];
    int          failures;

    function new();
      width_reg     = 16'd640;
      height_reg    = 16'd480;
      clip_x        = '0;
      clip_y        = '0;
      absolute_mode = 1'b0;
      updated_flag  = 1'b0;
      buttons       = '0;
      pos_x         = POS_CENTER;
      pos_y         = POS_CENTER;
      wheel_sum     = 0;
      failures      = 0;
    endfunction

    function void set_register(logic [7:0] index, logic [15:0] value);
      case (index)
        REG_WIDTH:    width_reg = value;
        REG_HEIGHT:   height_reg = value;
        REG_OFFSET_X: clip_x = value;
        REG_OFFSET_Y: clip_y = value;
        default: ;
      endcase
    endfunction

    // clip, clamp to the resolution, then scale to 0..65535 rounding half up
    function logic [15:0] scale_axis(logic [15:0] host, logic [15:0] clip, logic [15:0] res);
      longint unsigned r, p, d, s;
      r = (res < 16'd2) ? 64'd2 : 64'(res);
      p = (host > clip) ? 64'(host) - 64'(clip) : 64'd0;
      if (p > r) p = r;
      d = r - 1;
      s = (2 * p * 65535 + d) / (2 * d);
      if (s > 65535) s = 65535;
      return s[15:0];
    endfunction

    function apbp_out_t predict_reply(apbp_in_t it);
      apbp_out_t   r;
      logic [15:0] nx, ny;
      int          t;
      r = '0;
      if (op_t'(it.operation) == OP_PORT_READ) begin
        if (it.key_word == MAGIC_WORD) begin
          case (it.command_code)
            CMD_VERSION: begin
              r.second_word  = MAGIC_WORD;
              r.written_mask = MASK_VERSION;
            end
            CMD_DATA: begin
              r.read_data    = {26'd0, buttons, 3'd0};
              r.second_word  = {16'd0, pos_x};
              r.third_word   = pos_y;
              r.fourth_word  = wheel_sum[7:0];
              r.written_mask = MASK_DATA;
              wheel_sum      = 0;
            end
            CMD_STATUS: begin
              r.read_data    = updated_flag ? STATUS_UPDATED : 32'd0;
              r.written_mask = MASK_STATUS;
              updated_flag   = 1'b0;
            end
            CMD_POINTER: begin
              r.read_data = MAGIC_WORD;
              if (it.sub_command == SUB_ENABLE) begin
              end else if (it.sub_command == SUB_RELATIVE) begin
                absolute_mode = 1'b0;
                buttons       = '0;
                wheel_sum     = 0;
              end else if (it.sub_command == SUB_ABSOLUTE) begin
                absolute_mode = 1'b1;
                buttons       = '0;
                wheel_sum     = 0;
              end else begin
                r.unknown_request = 1'b1;
              end
            end
            default: begin
              r.read_data       = MAGIC_WORD;
              r.unknown_request = 1'b1;
            end
          endcase
        end
      end else if (absolute_mode) begin
        case (op_t'(it.operation))
          OP_MOVE: begin
            nx = scale_axis(it.host_x, clip_x, width_reg);
            ny = scale_axis(it.host_y, clip_y, height_reg);
            if (nx != pos_x || ny != pos_y) begin
              updated_flag  = 1'b1;
              r.event_taken = 1'b1;
            end
            pos_x = nx;
            pos_y = ny;
          end
          OP_BUTTONS: begin
            buttons       = {it.left_down, it.right_down, it.middle_down};
            updated_flag  = 1'b1;
            r.event_taken = 1'b1;
          end
          default: begin
            t = wheel_sum + int'($signed(it.wheel_step));
            if (t > 127) t = 127;
            if (t < -128) t = -128;
            wheel_sum     = t;
            updated_flag  = 1'b1;
            r.event_taken = 1'b1;
          end
        endcase
      end
      return r;
    endfunction

    function void note_item(apbp_in_t it);
      expected_replies.push_back(predict_reply(it));
    endfunction

    function string describe(apbp_out_t r);
      return $sformatf("a=%h b=%h c=%h d=%h mask=%h ev=%b unk=%b", r.read_data,
                       r.second_word, r.third_word, r.fourth_word, r.written_mask,
                       r.event_taken, r.unknown_request);
    endfunction

    function void check_reply(apbp_out_t got);
      apbp_out_t want;
      if (expected_replies.size() == 0) begin
        if (failures < 10) $display("unexpected reply: %s", describe(got));
        failures++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.read_data !== want.read_data || got.second_word !== want.second_word ||
          got.third_word !== want.third_word || got.fourth_word !== want.fourth_word ||
          got.written_mask !== want.written_mask || got.event_taken !== want.event_taken ||
          got.unknown_request !== want.unknown_request) begin
        if (failures < 10) begin
          $display("mismatch at %0t: expected %s", $realtime, describe(want));
          $display("                 actual   %s", describe(got));
        end
        failures++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  apbp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  apbp_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pointer_tracker tracker;
  bit             quiet = 1'b0;
  bit             hold_request = 1'b0;
  logic [15:0]    cur_width = 16'd640, cur_height = 16'd480;
  logic [15:0]    cur_clip_x = '0, cur_clip_y = '0;

  absolute_pointer_backdoor_port dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // overall time limit
  initial begin
    #5_000_000;
    $display("absolute_pointer_backdoor_port_test failed");
    $finish;
  end

  // reply checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_reply(out_data);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 7);
      end
    end
  end

  // random content in every field, overridden where it matters
  function automatic apbp_in_t noise_item();
    apbp_in_t it;
    it.operation    = 2'($urandom);
    it.key_word     = $urandom;
    it.command_code = 16'($urandom);
    it.sub_command  = $urandom;
    it.host_x       = 16'($urandom);
    it.host_y       = 16'($urandom);
    it.left_down    = 1'($urandom);
    it.right_down   = 1'($urandom);
    it.middle_down  = 1'($urandom);
    it.wheel_step   = 16'($urandom);
    return it;
  endfunction

  function automatic apbp_in_t read_item(logic [31:0] key, logic [15:0] cmd, logic [31:0] sub);
    apbp_in_t it;
    it              = noise_item();
    it.operation    = OP_PORT_READ;
    it.key_word     = key;
    it.command_code = cmd;
    it.sub_command  = sub;
    return it;
  endfunction

  function automatic apbp_in_t move_item(logic [15:0] x, logic [15:0] y);
    apbp_in_t it;
    it           = noise_item();
    it.operation = OP_MOVE;
    it.host_x    = x;
    it.host_y    = y;
    return it;
  endfunction

  function automatic apbp_in_t button_item(logic l, logic r, logic m);
    apbp_in_t it;
    it             = noise_item();
    it.operation   = OP_BUTTONS;
    it.left_down   = l;
    it.right_down  = r;
    it.middle_down = m;
    return it;
  endfunction

  function automatic apbp_in_t wheel_item(logic [15:0] w);
    apbp_in_t it;
    it            = noise_item();
    it.operation  = OP_WHEEL;
    it.wheel_step = w;
    return it;
  endfunction

  // mostly well-formed traffic; pointer commands favour absolute mode, with occasional switches to relative
  function automatic apbp_in_t random_item();
    apbp_in_t    it;
    int          pick, sel;
    logic [31:0] key, sub;
    logic [15:0] cmd;
    int          reach_x, reach_y;
    pick = $urandom_range(99);
    if (pick < 40) begin
      key = MAGIC_WORD;
      if ($urandom_range(99) < 8)
        key = $urandom_range(1) ? $urandom : MAGIC_WORD ^ (32'd1 << $urandom_range(31));
      sel = $urandom_range(99);
      sub = $urandom;
      if (sel < 30) cmd = CMD_DATA;
      else if (sel < 55) cmd = CMD_STATUS;
      else if (sel < 65) cmd = CMD_VERSION;
      else if (sel < 90) begin
        cmd = CMD_POINTER;
        sel = $urandom_range(99);
        if (sel < 50) sub = SUB_ABSOLUTE;
        else if (sel < 65) sub = SUB_ENABLE;
        else if (sel < 77) sub = SUB_RELATIVE;
      end else cmd = 16'($urandom);
      it = read_item(key, cmd, sub);
    end else if (pick < 65) begin
      reach_x = int'(cur_clip_x) + int'(cur_width) + 8;
      reach_y = int'(cur_clip_y) + int'(cur_height) + 8;
      if (reach_x > 65535) reach_x = 65535;
      if (reach_y > 65535) reach_y = 65535;
      it = move_item($urandom_range(1) ? 16'($urandom_range(0, reach_x)) : 16'($urandom),
                     $urandom_range(1) ? 16'($urandom_range(0, reach_y)) : 16'($urandom));
    end else if (pick < 80) begin
      it = button_item(1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      it = wheel_item(($urandom_range(99) < 70) ? 16'($urandom_range(0, 20) - 10)
                                                : 16'($urandom));
    end
    return it;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(apbp_in_t it);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_item(it);
  endtask

  task automatic write_register(logic [7:0] index, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every outstanding reply, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [15:0] ox, logic [15:0] oy,
                           int count);
    wait_idle();
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    write_register(REG_OFFSET_X, ox);
    write_register(REG_OFFSET_Y, oy);
    cur_width  = w;
    cur_height = h;
    cur_clip_x = ox;
    cur_clip_y = oy;
    // switch to absolute mode and move to the corner, clipped when offsets are set
    send_item(read_item(MAGIC_WORD, CMD_POINTER, SUB_ABSOLUTE));
    send_item(move_item(16'd0, 16'd0));
    repeat (count) send_item(random_item());
  endtask

  // stimulus
  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // events while in relative mode are ignored
    send_item(move_item(16'd100, 16'd100));
    send_item(button_item(1'b1, 1'b1, 1'b1));
    send_item(wheel_item(16'd5));
    // wrong key leaves everything alone
    send_item(read_item(32'h0000_0000, CMD_VERSION, SUB_ABSOLUTE));
    send_item(read_item(32'hFFFF_FFFF, CMD_POINTER, SUB_ABSOLUTE));
    send_item(read_item(MAGIC_WORD, CMD_VERSION, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_STATUS, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_DATA, 32'd0));
    send_item(read_item(MAGIC_WORD, 16'hFFFF, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_POINTER, SUB_ENABLE));
    send_item(read_item(MAGIC_WORD, CMD_POINTER, 32'hFFFF_FFFF));
    send_item(read_item(MAGIC_WORD, CMD_POINTER, SUB_ABSOLUTE));
    // moves: corner, repeat with no change, beyond the screen, last pixel
    send_item(move_item(16'd0, 16'd0));
    send_item(move_item(16'd0, 16'd0));
    send_item(move_item(16'hFFFF, 16'hFFFF));
    send_item(move_item(16'd639, 16'd479));
    send_item(read_item(MAGIC_WORD, CMD_STATUS, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_STATUS, 32'd0));
    send_item(button_item(1'b1, 1'b1, 1'b1));
    // wheel saturates both ways
    send_item(wheel_item(16'h7FFF));
    send_item(wheel_item(16'h8000));
    send_item(wheel_item(16'd5));
    send_item(read_item(MAGIC_WORD, CMD_DATA, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_DATA, 32'd0));
    send_item(read_item(MAGIC_WORD, CMD_POINTER, SUB_RELATIVE));
    send_item(read_item(MAGIC_WORD, CMD_DATA, 32'd0));

    // largest resolution, with a long receiver hold-off while items keep coming
    run_phase(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 0);
    hold_request = 1'b1;
    repeat (170) send_item(random_item());
    // smallest resolution, no idling on either side
    quiet = 1'b1;
    run_phase(16'd2, 16'd2, 16'd0, 16'd0, 170);
    quiet = 1'b0;
    // moderate screens with offsets
    run_phase(16'($urandom_range(2, 2000)), 16'($urandom_range(2, 2000)),
              16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)), 170);
    // resolution below two and extreme offsets
    run_phase(16'd0, 16'd1, 16'hFFFF, 16'h8000, 170);
    // anything goes
    run_phase(16'($urandom_range(2, 65535)), 16'($urandom_range(2, 65535)),
              16'($urandom), 16'($urandom), 170);

    wait_idle();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("absolute_pointer_backdoor_port_test passed");
    end else begin
      $display("absolute_pointer_backdoor_port_test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/apbp_pkg.sv
src/apbp_div.sv
src/absolute_pointer_backdoor_port.sv
verif/absolute_pointer_backdoor_port_test.sv
